### hdl/histogram_fwhm_top_assert.svh
// Assertion macros for the histogram FWHM block
`ifndef HISTOGRAM_FWHM_TOP_ASSERT_SVH
`define HISTOGRAM_FWHM_TOP_ASSERT_SVH

// Checked while out of reset
`define HFW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hfw assertion failed");

// Checked on every edge, reset included
`define HFW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hfw assertion failed");

`endif

### hdl/hfw_pkg.sv
`default_nettype none

package hfw_pkg;

  localparam int unsigned InCountW  = 32;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned WidthW    = 42;
  localparam int unsigned BinFieldW = 11;
  localparam int unsigned PeakCntW  = 32;

  localparam logic [CfgW-1:0] BinWidthReset = 32'h0001_0000;

  typedef enum logic [2:0] {
    S_LOAD,
    S_LEFT_RD,
    S_LEFT_CHK,
    S_RIGHT_RD,
    S_RIGHT_CHK,
    S_MUL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_right;
    logic lo_dec;
    logic hi_inc;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic lo_zero;
    logic hi_end;
    logic above;
  } sts_t;

endpackage

`default_nettype wire

### hdl/hfw_in_if.sv
`default_nettype none

interface hfw_in_if;
  logic                             valid;
  logic                             ready;
  logic [hfw_pkg::InCountW-1:0]     bin_count;
  logic                             last_bin;

  modport source (output valid, output bin_count, output last_bin, input ready);
  modport sink   (input valid, input bin_count, input last_bin, output ready);
endinterface

`default_nettype wire

### hdl/hfw_out_if.sv
`default_nettype none

interface hfw_out_if;
  logic                              valid;
  logic                              ready;
  logic [hfw_pkg::WidthW-1:0]        width;
  logic [hfw_pkg::BinFieldW-1:0]     peak_bin;
  logic [hfw_pkg::PeakCntW-1:0]      peak_count;
  logic [hfw_pkg::BinFieldW-1:0]     left_edge_bin;
  logic [hfw_pkg::BinFieldW-1:0]     right_edge_bin;
  logic                              overflow;

  modport source (output valid, output width, output peak_bin, output peak_count,
                  output left_edge_bin, output right_edge_bin, output overflow,
                  input ready);
  modport sink   (input valid, input width, input peak_bin, input peak_count,
                  input left_edge_bin, input right_edge_bin, input overflow,
                  output ready);
endinterface

`default_nettype wire

### hdl/hfw_ctrl.sv
`default_nettype none

module hfw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  input  wire logic          out_ready_i,
  input  wire hfw_pkg::sts_t sts_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output hfw_pkg::cmd_t      cmd_o
);

  hfw_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hfw_pkg::S_LOAD: begin
        if (in_valid_i && in_last_i) state_d = hfw_pkg::S_LEFT_RD;
      end
      hfw_pkg::S_LEFT_RD: begin
        state_d = sts_i.lo_zero ? hfw_pkg::S_RIGHT_RD : hfw_pkg::S_LEFT_CHK;
      end
      hfw_pkg::S_LEFT_CHK: begin
        state_d = sts_i.above ? hfw_pkg::S_LEFT_RD : hfw_pkg::S_RIGHT_RD;
      end
      hfw_pkg::S_RIGHT_RD: begin
        state_d = sts_i.hi_end ? hfw_pkg::S_MUL : hfw_pkg::S_RIGHT_CHK;
      end
      hfw_pkg::S_RIGHT_CHK: begin
        state_d = sts_i.above ? hfw_pkg::S_RIGHT_RD : hfw_pkg::S_MUL;
      end
      hfw_pkg::S_MUL: begin
        state_d = hfw_pkg::S_DONE;
      end
      hfw_pkg::S_DONE: begin
        if (out_free) state_d = hfw_pkg::S_LOAD;
      end
      default: state_d = hfw_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hfw_pkg::S_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      hfw_pkg::S_LEFT_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      hfw_pkg::S_LEFT_CHK: begin
        cmd_o.lo_dec = sts_i.above;
      end
      hfw_pkg::S_RIGHT_RD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_right = 1'b1;
      end
      hfw_pkg::S_RIGHT_CHK: begin
        cmd_o.hi_inc = sts_i.above;
      end
      hfw_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
      end
      hfw_pkg::S_DONE: begin
        cmd_o.emit = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
    out_valid_d = cmd_o.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hfw_pkg::S_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hdl/hfw_datapath.sv
`default_nettype none

module hfw_datapath #(
  parameter int unsigned MAX_BINS   = 1024,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire hfw_pkg::cmd_t                     cmd_i,
  output hfw_pkg::sts_t                          sts_o,
  input  wire logic [hfw_pkg::InCountW-1:0]      bin_count_i,
  input  wire logic                              last_bin_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [hfw_pkg::CfgW-1:0]          cfg_wdata_i,
  output logic      [hfw_pkg::WidthW-1:0]        width_o,
  output logic      [hfw_pkg::BinFieldW-1:0]     peak_bin_o,
  output logic      [hfw_pkg::PeakCntW-1:0]      peak_count_o,
  output logic      [hfw_pkg::BinFieldW-1:0]     left_edge_bin_o,
  output logic      [hfw_pkg::BinFieldW-1:0]     right_edge_bin_o,
  output logic                                   overflow_o
);

  localparam int unsigned IdxW  = $clog2(MAX_BINS);
  localparam int unsigned CntW  = $clog2(MAX_BINS + 1);
  localparam int unsigned ProdW = IdxW + hfw_pkg::CfgW;

  logic [COUNT_BITS-1:0] mem_q [MAX_BINS];

  logic [CntW-1:0]             loaded_q, loaded_d;
  logic [IdxW-1:0]             best_bin_q, best_bin_d;
  logic [COUNT_BITS-1:0]       best_cnt_q, best_cnt_d;
  logic                        ovf_q, ovf_d;
  logic [hfw_pkg::CfgW-1:0]    bin_width_q;
  logic [IdxW-1:0]             lo_q, lo_d, hi_q, hi_d;
  logic [COUNT_BITS-1:0]       rdata_q;
  logic [ProdW-1:0]            prod_q;
  logic [COUNT_BITS-1:0]       cnt;
  logic                        wr_en;
  logic [IdxW-1:0]             rd_addr;
  logic [CntW-1:0]             hi_next;

  assign cnt     = COUNT_BITS'(bin_count_i);
  assign wr_en   = cmd_i.load && (loaded_q < CntW'(MAX_BINS));
  assign rd_addr = cmd_i.rd_right ? hi_q : lo_q;
  assign hi_next = CntW'(hi_q) + CntW'(1);

  assign sts_o.lo_zero = (lo_q == '0);
  assign sts_o.hi_end  = (hi_next >= loaded_q);
  assign sts_o.above   = {rdata_q, 1'b0} > {1'b0, best_cnt_q};

  always_comb begin
    loaded_d   = loaded_q;
    best_bin_d = best_bin_q;
    best_cnt_d = best_cnt_q;
    ovf_d      = ovf_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    if (cmd_i.load) begin
      if (wr_en) begin
        if (loaded_q == '0 || cnt > best_cnt_q) begin
          best_cnt_d = cnt;
          best_bin_d = loaded_q[IdxW-1:0];
        end
        loaded_d = loaded_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (last_bin_i) begin
        lo_d = best_bin_d;
        hi_d = best_bin_d;
      end
    end
    if (cmd_i.lo_dec) lo_d = lo_q - IdxW'(1);
    if (cmd_i.hi_inc) hi_d = hi_q + IdxW'(1);
    if (cmd_i.emit) begin
      loaded_d   = '0;
      best_bin_d = '0;
      best_cnt_d = '0;
      ovf_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      best_bin_q  <= '0;
      best_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      bin_width_q <= hfw_pkg::BinWidthReset;
    end else begin
      loaded_q   <= loaded_d;
      best_bin_q <= best_bin_d;
      best_cnt_q <= best_cnt_d;
      ovf_q      <= ovf_d;
      if (cfg_we_i) bin_width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[loaded_q[IdxW-1:0]] <= cnt;
    if (cmd_i.rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.mul) prod_q <= ProdW'(hi_q - lo_q) * ProdW'(bin_width_q);
    if (cmd_i.emit) begin
      width_o          <= hfw_pkg::WidthW'(prod_q);
      peak_bin_o       <= hfw_pkg::BinFieldW'(CntW'(best_bin_q) + CntW'(1));
      peak_count_o     <= hfw_pkg::PeakCntW'(best_cnt_q);
      left_edge_bin_o  <= hfw_pkg::BinFieldW'(CntW'(lo_q) + CntW'(1));
      right_edge_bin_o <= hfw_pkg::BinFieldW'(hi_next);
      overflow_o       <= ovf_q;
    end
  end

endmodule

`default_nettype wire

### hdl/histogram_fwhm_top.sv
// Load: one bin per cycle, ready high only while loading, not while measuring or
// waiting to hand the result on. After the last bin the block walks left, then
// right, from the peak; each step is a registered read of the bin store and a
// compare against half the peak count, then a multiply and an output register.
// Reset (async, active low) clears control, bin count, peak and bin_width
// (to 1.0); the bin store is not cleared.
`default_nettype none

module histogram_fwhm_top #(
  parameter int unsigned MAX_BINS   = 1024,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  hfw_in_if.sink                            in_i,
  hfw_out_if.source                         out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [hfw_pkg::CfgW-1:0]     cfg_wdata_i
);

  hfw_pkg::cmd_t cmd;
  hfw_pkg::sts_t sts;

  hfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_bin),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  hfw_datapath #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .bin_count_i      (in_i.bin_count),
    .last_bin_i       (in_i.last_bin),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .width_o          (out_o.width),
    .peak_bin_o       (out_o.peak_bin),
    .peak_count_o     (out_o.peak_count),
    .left_edge_bin_o  (out_o.left_edge_bin),
    .right_edge_bin_o (out_o.right_edge_bin),
    .overflow_o       (out_o.overflow)
  );

endmodule

`default_nettype wire

### hdl/hfw_checker.sv
`default_nettype none

`include "histogram_fwhm_top_assert.svh"

module hfw_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               in_last,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [hfw_pkg::WidthW-1:0]         out_width,
  input wire logic [hfw_pkg::BinFieldW-1:0]      out_left,
  input wire logic [hfw_pkg::BinFieldW-1:0]      out_right
);

  `HFW_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |-> !out_valid)

  `HFW_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid)

  `HFW_ASSERT(a_busy_after_last, clk_i, rst_ni,
              in_valid && in_ready && in_last |=> !in_ready ##1 !in_ready ##1 !in_ready)

  `HFW_ASSERT(a_zero_span, clk_i, rst_ni,
              out_valid && out_left == out_right |-> out_width == '0)

endmodule

bind histogram_fwhm_top hfw_checker u_hfw_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_last   (in_i.last_bin),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_width (out_o.width),
  .out_left  (out_o.left_edge_bin),
  .out_right (out_o.right_edge_bin)
);

`default_nettype wire
